>>> hw/rtl/png_scanline_unfilter_rgb8_defines.svh
// assertion macros shared by the rtl that carries checks
`ifndef PNG_SCANLINE_UNFILTER_RGB8_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_RGB8_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define PSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("png unfilter check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define PSU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("png unfilter check failed");

`endif

>>> hw/rtl/psu_pkg.sv
`default_nettype none

package psu_pkg;

    localparam int BYTES_PER_PIXEL = 3;
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int HEIGHT_MAX      = 16384;

    localparam int DATA_W     = 8;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 15;
    localparam int COL_W      = 14;
    localparam int ROW_W      = 14;
    localparam int LEN_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int OP_W       = 3;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // filter type byte as found in the stream
    localparam logic [DATA_W-1:0] FILT_NONE  = 8'd0;
    localparam logic [DATA_W-1:0] FILT_SUB   = 8'd1;
    localparam logic [DATA_W-1:0] FILT_UP    = 8'd2;
    localparam logic [DATA_W-1:0] FILT_AVG   = 8'd3;
    localparam logic [DATA_W-1:0] FILT_PAETH = 8'd4;

    // decoded filter operation
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OP_W-1:0] OP_UP    = 3'd2;
    localparam logic [OP_W-1:0] OP_AVG   = 3'd3;
    localparam logic [OP_W-1:0] OP_PAETH = 3'd4;
    localparam logic [OP_W-1:0] OP_BAD   = 3'd5;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [OP_W-1:0]   op;
        logic [COL_W-1:0]  col;
        logic              zero_left;
        logic              zero_up;
        logic              eor;
        logic              eoi;
    } t_work;

    typedef struct packed {
        logic [DATA_W-1:0] pixel;
        logic              eor;
        logic              eoi;
        logic              bad;
    } t_res;

    function automatic logic [OP_W-1:0] decode_filter(input logic [DATA_W-1:0] f);
        logic [OP_W-1:0] op;
        case (f)
            FILT_NONE:  op = OP_NONE;
            FILT_SUB:   op = OP_SUB;
            FILT_UP:    op = OP_UP;
            FILT_AVG:   op = OP_AVG;
            FILT_PAETH: op = OP_PAETH;
            default:    op = OP_BAD;
        endcase
        return op;
    endfunction

    // paeth predictor: pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
    function automatic logic [DATA_W-1:0] paeth(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c
    );
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        logic [DATA_W-1:0]  pr;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = da[10] ? 11'(-da) : 11'(da);
        pb = db[10] ? 11'(-db) : 11'(db);
        pc = dc[10] ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            pr = a;
        end else if (pb <= pc) begin
            pr = b;
        end else begin
            pr = c;
        end
        return pr;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/psu_ram.sv
`default_nettype none

module psu_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/psu_fifo.sv
`default_nettype none

module psu_fifo #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty,
    output logic      [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/psu_front.sv
`default_nettype none

module psu_front #(
    parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [psu_pkg::DATA_W-1:0]      i_data_byte,
    input  wire logic                            i_cfg_we,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_push,
    output psu_pkg::t_work                       o_work
);

    localparam int COL_W     = psu_pkg::COL_W;
    localparam int ROW_W     = psu_pkg::ROW_W;
    localparam int LEN_W     = psu_pkg::LEN_W;
    localparam int HEIGHT_W  = psu_pkg::HEIGHT_W;
    localparam int WIDTH_W   = psu_pkg::WIDTH_W;
    localparam int BPP       = psu_pkg::BYTES_PER_PIXEL;
    localparam int ROW_BYTES = MAX_WIDTH * BPP;

    logic                      r_await;
    logic [psu_pkg::OP_W-1:0]  r_op;
    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_row;
    logic [LEN_W-1:0]          r_row_len;
    logic [HEIGHT_W-1:0]       r_height;

    logic                      n_await;
    logic [psu_pkg::OP_W-1:0]  n_op;
    logic [COL_W-1:0]          n_col;
    logic [ROW_W-1:0]          n_row;
    logic [LEN_W-1:0]          n_row_len;
    logic [HEIGHT_W-1:0]       n_height;

    logic [WIDTH_W-1:0]  cfg_w;
    logic [31:0]         w_clamp;
    logic [HEIGHT_W-1:0] h_clamp;
    logic [LEN_W-1:0]    col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic [COL_W-1:0]    col_addr;
    logic                eor;
    logic                eoi;

    // bounds are clamped once at write time
    always_comb begin
        cfg_w = i_cfg_data[WIDTH_W-1:0];
        if (cfg_w == '0) begin
            w_clamp = 32'd1;
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            w_clamp = 32'(MAX_WIDTH);
        end else begin
            w_clamp = 32'(cfg_w);
        end
        if (i_cfg_data == '0) begin
            h_clamp = HEIGHT_W'(1);
        end else if (i_cfg_data > HEIGHT_W'(psu_pkg::HEIGHT_MAX)) begin
            h_clamp = HEIGHT_W'(psu_pkg::HEIGHT_MAX);
        end else begin
            h_clamp = i_cfg_data;
        end
    end

    always_comb begin
        col_inc  = {1'b0, r_col} + LEN_W'(1);
        row_inc  = {1'b0, r_row} + HEIGHT_W'(1);
        eor      = (col_inc >= r_row_len);
        eoi      = eor && (row_inc >= r_height);
        col_addr = (32'(r_col) >= 32'(ROW_BYTES)) ? COL_W'(ROW_BYTES - 1) : r_col;
    end

    assign o_push          = i_accept && !r_await;
    assign o_work.data      = i_data_byte;
    assign o_work.op        = r_op;
    assign o_work.col       = col_addr;
    assign o_work.zero_left = (r_col < COL_W'(BPP));
    assign o_work.zero_up   = (r_row == '0);
    assign o_work.eor       = eor;
    assign o_work.eoi       = eoi;

    always_comb begin
        n_await   = r_await;
        n_op      = r_op;
        n_col     = r_col;
        n_row     = r_row;
        n_row_len = r_row_len;
        n_height  = r_height;
        if (i_accept) begin
            if (r_await) begin
                n_op    = psu_pkg::decode_filter(i_data_byte);
                n_await = 1'b0;
                n_col   = '0;
            end else if (eor) begin
                n_col   = '0;
                n_await = 1'b1;
                n_row   = eoi ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
        if (i_cfg_we) begin
            case (i_cfg_index)
                psu_pkg::REG_IMAGE_WIDTH:  n_row_len = LEN_W'(w_clamp * BPP);
                psu_pkg::REG_IMAGE_HEIGHT: n_height  = h_clamp;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await   <= 1'b1;
            r_op      <= psu_pkg::OP_NONE;
            r_col     <= '0;
            r_row     <= '0;
            r_row_len <= LEN_W'(BPP);
            r_height  <= HEIGHT_W'(1);
        end else begin
            r_await   <= n_await;
            r_op      <= n_op;
            r_col     <= n_col;
            r_row     <= n_row;
            r_row_len <= n_row_len;
            r_height  <= n_height;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/psu_back.sv
`default_nettype none

module psu_back #(
    parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_work_valid,
    input  wire psu_pkg::t_work                           i_work,
    input  wire logic [$clog2(psu_pkg::OUT_DEPTH+1)-1:0]  i_out_count,
    output logic                                          o_pop,
    output logic                                          o_res_push,
    output psu_pkg::t_res                                 o_res
);

    localparam int DW        = psu_pkg::DATA_W;
    localparam int BPP       = psu_pkg::BYTES_PER_PIXEL;
    localparam int ROW_BYTES = MAX_WIDTH * BPP;
    localparam int AW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int CW        = $clog2(psu_pkg::OUT_DEPTH + 1);

    psu_pkg::t_work  r_s1;
    logic            r_s1_valid;
    logic [DW-1:0]   r_left [BPP];
    logic [DW-1:0]   r_up   [BPP];

    logic [31:0]     raddr_ext;
    logic [31:0]     waddr_ext;
    logic [DW-1:0]   up_rd;
    logic [CW:0]     in_use;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    logic [DW-1:0]   c;
    logic [DW:0]     ab_sum;
    logic [DW-1:0]   res;
    logic            bad;

    // keep room in the result queue for everything in flight
    assign in_use = {1'b0, i_out_count} + (CW + 1)'(r_s1_valid);
    assign o_pop  = i_work_valid && (in_use < (CW + 1)'(psu_pkg::OUT_DEPTH));

    assign raddr_ext = 32'(i_work.col);
    assign waddr_ext = 32'(r_s1.col);

    psu_ram #(
        .WIDTH (DW),
        .DEPTH (ROW_BYTES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata (res),
        .i_raddr (raddr_ext[AW-1:0]),
        .o_rdata (up_rd)
    );

    always_comb begin
        a      = r_s1.zero_left ? '0 : r_left[0];
        b      = r_s1.zero_up   ? '0 : up_rd;
        c      = r_s1.zero_left ? '0 : r_up[0];
        ab_sum = {1'b0, a} + {1'b0, b};
        bad    = 1'b0;
        case (r_s1.op)
            psu_pkg::OP_NONE:  res = r_s1.data;
            psu_pkg::OP_SUB:   res = r_s1.data + a;
            psu_pkg::OP_UP:    res = r_s1.data + b;
            psu_pkg::OP_AVG:   res = r_s1.data + ab_sum[DW:1];
            psu_pkg::OP_PAETH: res = r_s1.data + psu_pkg::paeth(a, b, c);
            default: begin
                res = r_s1.data;
                bad = 1'b1;
            end
        endcase
    end

    assign o_res_push  = r_s1_valid;
    assign o_res.pixel = res;
    assign o_res.eor   = r_s1.eor;
    assign o_res.eoi   = r_s1.eoi;
    assign o_res.bad   = bad;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_work;
        end
        if (r_s1_valid) begin
            for (int i = 0; i < BPP - 1; i++) begin
                r_left[i] <= r_left[i+1];
                r_up[i]   <= r_up[i+1];
            end
            r_left[BPP-1] <= res;
            r_up[BPP-1]   <= b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/png_scanline_unfilter_rgb8.sv
// path: a sample byte goes from the input through the work queue, the reconstruct register and the result queue
// throughput: one byte per cycle sustained while the consumer keeps popping; a filter-type byte gives no result
// the rate is set by the reconstruct stage and the row memory's one read port
// reset (i_rst_n, synchronous, active low): counters, queues and bounds cleared, width 1,
// height 1, next byte is a filter type; the row memory is not cleared and needs no pass
`default_nettype none

`include "png_scanline_unfilter_rgb8_defines.svh"

module png_scanline_unfilter_rgb8 #(
    parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input queue side
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [psu_pkg::DATA_W-1:0]      i_data_byte,
    // result queue side
    output logic                                 empty,
    input  wire logic                            pop,
    output logic      [psu_pkg::DATA_W-1:0]      o_pixel_byte,
    output logic                                 o_end_of_row,
    output logic                                 o_end_of_image,
    output logic                                 o_bad_filter,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int MID_CW = $clog2(psu_pkg::MID_DEPTH + 1);
    localparam int OUT_CW = $clog2(psu_pkg::OUT_DEPTH + 1);

    logic               accept;
    logic               mid_push;
    psu_pkg::t_work     mid_in;
    psu_pkg::t_work     mid_out;
    logic               mid_empty;
    logic [MID_CW-1:0]  mid_count;
    logic               back_pop;
    logic               res_push;
    psu_pkg::t_res      res_in;
    psu_pkg::t_res      res_out;
    logic               out_full;
    logic [OUT_CW-1:0]  out_count;

    // an input transfer happens whenever push is high and the work queue has room
    assign accept = push && !full;

    // front: tracks column and row, decodes the filter byte, tags each sample
    psu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (mid_push),
        .o_work      (mid_in)
    );

    // short work queue decouples the classifier from the reconstruct stage
    psu_fifo #(
        .WIDTH ($bits(psu_pkg::t_work)),
        .DEPTH (psu_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (back_pop),
        .o_data  (mid_out),
        .o_full  (full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    // back: reads the row above, runs the filter, writes the row back
    psu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (!mid_empty),
        .i_work       (mid_out),
        .i_out_count  (out_count),
        .o_pop        (back_pop),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue keeps the back running while the consumer stalls
    psu_fifo #(
        .WIDTH ($bits(psu_pkg::t_res)),
        .DEPTH (psu_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_pixel_byte   = res_out.pixel;
    assign o_end_of_row   = res_out.eor;
    assign o_end_of_image = res_out.eoi;
    assign o_bad_filter   = res_out.bad;

    // the credit check must keep the result queue from overflowing
    `PSU_ASSERT_IMP(a_out_no_overflow, res_push, !out_full || pop)
    // the back only takes work that is there
    `PSU_ASSERT_IMP(a_mid_pop_valid, back_pop, !mid_empty && mid_count != '0)
    // every item taken from the work queue yields a result in the next cycle
    `PSU_ASSERT_NXT(a_res_follows, back_pop, res_push)
    // end of image only ever comes on the last byte of a row
    `PSU_ASSERT_IMP(a_eoi_has_eor, !empty && o_end_of_image, o_end_of_row)

endmodule

`default_nettype wire
